/* design/assert_macros.svh */
// Assertion macros shared by the prime counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* design/tdpc_pkg.sv */
// Package with the command and status types and output constants of the prime counter.
`default_nettype none

package tdpc_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int OUT_DATA_WIDTH = 40;
    localparam int OUT_PAD_WIDTH  = OUT_DATA_WIDTH - COUNT_WIDTH - 1;

    typedef struct packed {
        logic load;
        logic start_div;
        logic step;
        logic finish;
        logic prime;
    } t_cmd;

    typedef struct packed {
        logic lt_two;
        logic sq_gt_n;
        logic last_bit;
        logic rem_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* design/tdpc_ctrl.sv */
// Controller state machine that sequences the trial divisions of one candidate.
`default_nettype none
`include "assert_macros.svh"

module tdpc_ctrl
    import tdpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_prime, n_prime;

    always_comb begin
        n_state    = r_state;
        n_prime    = r_prime;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.lt_two) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else if (i_st.sq_gt_n) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_st.last_bit) begin
                    if (i_st.rem_zero) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.prime  = r_prime;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    `ASSERT_CLK(a_div_retry, (r_state == S_DIV && i_st.last_bit && !i_st.rem_zero) |=> (r_state == S_CHECK), "nonzero remainder did not move to the next divisor")
    `ASSERT_CLK(a_load_from_idle, o_cmd.load |=> (r_state == S_CHECK && !o_s_tready), "accepted candidate did not start a search")
    `ASSERT_ALWAYS(a_one_cmd, $onehot0({o_cmd.load, o_cmd.start_div, o_cmd.step, o_cmd.finish}), "more than one datapath command at once")

endmodule

`default_nettype wire

/* design/tdpc_dp.sv */
// Datapath with divisor and square registers, bit-serial remainder unit, prime count and output register.
`default_nettype none
`include "assert_macros.svh"

module tdpc_dp
    import tdpc_pkg::*;
#(
    parameter int CAND_WIDTH = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [CAND_WIDTH-1:0]     i_cand,
    input  wire t_cmd                      i_cmd,
    output t_status                        o_st,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [OUT_DATA_WIDTH-1:0]      o_m_tdata
);

    localparam int DW  = (CAND_WIDTH + 1) / 2 + 1;
    localparam int SQW = 2 * DW;
    localparam int BW  = $clog2(CAND_WIDTH);

    logic [CAND_WIDTH-1:0]  r_n;
    logic [CAND_WIDTH-1:0]  r_shift;
    logic [DW-1:0]          r_d;
    logic [SQW-1:0]         r_sq;
    logic [DW-1:0]          r_rem;
    logic [BW-1:0]          r_bit;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_m_valid;
    logic                   r_out_prime;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    assign trial    = {r_rem, r_shift[CAND_WIDTH-1]};
    assign ge       = trial >= {1'b0, r_d};
    assign rem_next = ge ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
    assign n_count  = r_count + COUNT_WIDTH'(i_cmd.prime);

    assign o_st.lt_two   = (r_n[CAND_WIDTH-1:1] == '0);
    assign o_st.sq_gt_n  = r_sq > SQW'(r_n);
    assign o_st.last_bit = (r_bit == '0);
    assign o_st.rem_zero = (rem_next == '0);
    assign o_st.out_free = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{OUT_PAD_WIDTH{1'b0}}, r_out_count, r_out_prime};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_cand;
            r_d  <= DW'(2);
            r_sq <= SQW'(4);
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_shift <= r_n;
            r_bit   <= BW'(CAND_WIDTH - 1);
        end
        if (i_cmd.step) begin
            r_rem   <= rem_next;
            r_shift <= {r_shift[CAND_WIDTH-2:0], 1'b0};
            r_bit   <= r_bit - BW'(1);
            if (o_st.last_bit) begin
                r_d  <= r_d + DW'(1);
                r_sq <= r_sq + SQW'({r_d, 1'b0}) + SQW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_out_prime <= i_cmd.prime;
            r_out_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_finish_free, i_cmd.finish |-> o_st.out_free, "result written over an untaken result")
    `ASSERT_CLK(a_count_step, i_cmd.finish |=> (r_count == $past(n_count) && r_out_count == r_count), "prime count and result disagree")
    `ASSERT_CLK(a_count_hold, !i_cmd.finish |=> $stable(r_count), "prime count changed without a result")

endmodule

`default_nettype wire

/* design/trial_division_prime_counter.sv */
// Top level of the trial-division prime counter.
// Candidates below 4 are settled in the check state with no division; larger ones try
// divisors from 2 upward until one divides the candidate (composite) or its square
// exceeds it (prime). One candidate at a time, accepted only in idle; each divisor takes
// a pass of the bit-serial remainder unit over every candidate bit, then a compare.
// Reset: synchronous active-low i_rst_n clears the controller, output valid and prime count.
`default_nettype none

module trial_division_prime_counter
    import tdpc_pkg::*;
#(
    parameter int CAND_WIDTH = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [CAND_WIDTH-1:0] candidate, rest zero
    input  wire logic [((CAND_WIDTH+7)/8)*8-1:0]   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [0] is_prime, [32:1] prime_count, rest zero
    output logic [OUT_DATA_WIDTH-1:0]              o_m_tdata
);

    t_cmd    cmd;
    t_status st;

    tdpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tdpc_dp #(
        .CAND_WIDTH (CAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cand     (i_s_tdata[CAND_WIDTH-1:0]),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
